// File: rtl/cs2rgb_pkg.sv
// Shared types, constants and helper functions of the color converter.
package cs2rgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COMP_W     = 18;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * UNIT_W;
    localparam int WIDE_W     = 2 * FRAC_BITS + 1;
    localparam int QUANT_W    = WIDE_W + 8;
    localparam int CHAN_W     = 8;
    localparam int NUM_STAGES = 5;

    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;
    localparam logic signed [COMP_W-1:0] COMP_ONE = COMP_W'(1) << FRAC_BITS;
    localparam logic [QUANT_W-1:0] QUANT_HALF = QUANT_W'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic [1:0] {
        MODE_RGB  = 2'd0,
        MODE_HSV  = 2'd1,
        MODE_GRAY = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    // Channel order (red, green, blue) for each sextant of the hue circle.
    typedef enum logic [2:0] {
        SEXT_VTP = 3'd0,
        SEXT_QVP = 3'd1,
        SEXT_PVT = 3'd2,
        SEXT_PQV = 3'd3,
        SEXT_TPV = 3'd4,
        SEXT_VPQ = 3'd5
    } sextant_t;

    // First stage: clamped components and hue split into sextant and fraction.
    typedef struct packed {
        mode_t                 mode;
        logic [UNIT_W-1:0]     ca;
        logic [UNIT_W-1:0]     cb;
        logic [UNIT_W-1:0]     cc;
        logic [2:0]            hi;
        logic [FRAC_BITS-1:0]  f;
        logic [UNIT_W-1:0]     nf;
    } prep_t;

    // Second stage: the three factors that multiply value.
    typedef struct packed {
        mode_t                 mode;
        logic [UNIT_W-1:0]     ca;
        logic [UNIT_W-1:0]     cb;
        logic [UNIT_W-1:0]     cc;
        logic [2:0]            hi;
        logic [UNIT_W-1:0]     kp;
        logic [UNIT_W-1:0]     kq;
        logic [UNIT_W-1:0]     kt;
    } fact_t;

    // Third stage: p, q and t at double fraction precision.
    typedef struct packed {
        mode_t                 mode;
        logic [UNIT_W-1:0]     ca;
        logic [UNIT_W-1:0]     cb;
        logic [UNIT_W-1:0]     cc;
        logic [2:0]            hi;
        logic [WIDE_W-1:0]     p;
        logic [WIDE_W-1:0]     q;
        logic [WIDE_W-1:0]     t;
    } pqt_t;

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [COMP_W-1:0] x);
        logic [UNIT_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > COMP_ONE) begin
            res = UNIT_ONE;
        end else begin
            res = x[UNIT_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [WIDE_W-1:0] widen(input logic [UNIT_W-1:0] x);
        return {x, {FRAC_BITS{1'b0}}};
    endfunction

endpackage

// File: rtl/color_spec_to_rgb24.sv
// Color specification to 24-bit RGB converter: five register stages with a common stall.
// An accepted input word passes the prep, factor, p/q/t, channel and rounded-channel registers to its output.
// Throughput: one word per cycle; the five-stage pipeline holds as a whole only while
// a finished word waits at the output under stall.
// Reset clears the stage valid bits; the data registers are not reset.
module color_spec_to_rgb24
    import cs2rgb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic signed [COMP_W-1:0] comp_first,
    input  logic signed [COMP_W-1:0] comp_second,
    input  logic signed [COMP_W-1:0] comp_third,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CHAN_W-1:0]        red_out,
    output logic [CHAN_W-1:0]        green_out,
    output logic [CHAN_W-1:0]        blue_out
);

    logic                   en;
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    prep_t                  prep;
    pqt_t                   pqt;

    // All stages move together unless the output word is held.
    assign en       = !(valid_reg[NUM_STAGES-1] && out_stall);
    assign in_stall = !en;

    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];

    cs2rgb_prep u_prep (
        .clk         (clk),
        .en          (en),
        .mode        (mode),
        .comp_first  (comp_first),
        .comp_second (comp_second),
        .comp_third  (comp_third),
        .prep        (prep)
    );

    cs2rgb_pqt u_pqt (
        .clk  (clk),
        .en   (en),
        .prep (prep),
        .pqt  (pqt)
    );

    cs2rgb_quant u_quant (
        .clk       (clk),
        .en        (en),
        .pqt       (pqt),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output word is not held");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    a_hold_keeps_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("stage valid bits changed during a hold");

    a_words_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[NUM_STAGES-2]) |=> out_valid)
        else $error("word lost between the last two stages");
`endif

endmodule

// File: rtl/cs2rgb_prep.sv
// Input stage: clamping of the components and sextant split of the hue.
module cs2rgb_prep
    import cs2rgb_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [1:0]               mode,
    input  logic signed [COMP_W-1:0] comp_first,
    input  logic signed [COMP_W-1:0] comp_second,
    input  logic signed [COMP_W-1:0] comp_third,
    output prep_t                    prep
);

    prep_t                  prep_next;
    prep_t                  prep_reg;
    logic [FRAC_BITS-1:0]   hue;
    logic [FRAC_BITS+2:0]   hue6;

    // The hue wraps modulo one turn by keeping only its fraction bits.
    assign hue  = comp_first[FRAC_BITS-1:0];
    assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb
    begin
        prep_next.mode = mode_t'(mode);
        prep_next.ca   = clamp_unit(comp_first);
        prep_next.cb   = clamp_unit(comp_second);
        prep_next.cc   = clamp_unit(comp_third);
        prep_next.hi   = hue6[FRAC_BITS+2:FRAC_BITS];
        prep_next.f    = hue6[FRAC_BITS-1:0];
        prep_next.nf   = UNIT_ONE - {1'b0, hue6[FRAC_BITS-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

// File: rtl/cs2rgb_pqt.sv
// Two multiplier stages that form p, q and t of the hue conversion.
module cs2rgb_pqt
    import cs2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  prep_t prep,
    output pqt_t  pqt
);

    fact_t              fact_next;
    fact_t              fact_reg;
    pqt_t               pqt_next;
    pqt_t               pqt_reg;
    logic [PROD_W-1:0]  sf_prod;
    logic [PROD_W-1:0]  st_prod;
    logic [PROD_W-1:0]  p_prod;
    logic [PROD_W-1:0]  q_prod;
    logic [PROD_W-1:0]  t_prod;

    // Saturation times the rising and falling ramps, truncated to one unit scale.
    assign sf_prod = PROD_W'(prep.cb) * PROD_W'(prep.f);
    assign st_prod = PROD_W'(prep.cb) * PROD_W'(prep.nf);

    always_comb
    begin
        fact_next.mode = prep.mode;
        fact_next.ca   = prep.ca;
        fact_next.cb   = prep.cb;
        fact_next.cc   = prep.cc;
        fact_next.hi   = prep.hi;
        fact_next.kp   = UNIT_ONE - prep.cb;
        fact_next.kq   = UNIT_ONE - sf_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
        fact_next.kt   = UNIT_ONE - st_prod[FRAC_BITS+UNIT_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fact_reg <= fact_next;
        end
    end

    assign p_prod = PROD_W'(fact_reg.cc) * PROD_W'(fact_reg.kp);
    assign q_prod = PROD_W'(fact_reg.cc) * PROD_W'(fact_reg.kq);
    assign t_prod = PROD_W'(fact_reg.cc) * PROD_W'(fact_reg.kt);

    always_comb
    begin
        pqt_next.mode = fact_reg.mode;
        pqt_next.ca   = fact_reg.ca;
        pqt_next.cb   = fact_reg.cb;
        pqt_next.cc   = fact_reg.cc;
        pqt_next.hi   = fact_reg.hi;
        pqt_next.p    = p_prod[WIDE_W-1:0];
        pqt_next.q    = q_prod[WIDE_W-1:0];
        pqt_next.t    = t_prod[WIDE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pqt_reg <= pqt_next;
        end
    end

    assign pqt = pqt_reg;

endmodule

// File: rtl/cs2rgb_quant.sv
// Channel selection by mode and sextant, then rounding of each channel to 8 bits.
module cs2rgb_quant
    import cs2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  pqt_t              pqt,
    output logic [CHAN_W-1:0] red_out,
    output logic [CHAN_W-1:0] green_out,
    output logic [CHAN_W-1:0] blue_out
);

    logic [WIDE_W-1:0]  vw;
    logic [WIDE_W-1:0]  r_next;
    logic [WIDE_W-1:0]  g_next;
    logic [WIDE_W-1:0]  b_next;
    logic [WIDE_W-1:0]  r_reg;
    logic [WIDE_W-1:0]  g_reg;
    logic [WIDE_W-1:0]  b_reg;
    logic [CHAN_W-1:0]  red_next;
    logic [CHAN_W-1:0]  green_next;
    logic [CHAN_W-1:0]  blue_next;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;

    function automatic logic [CHAN_W-1:0] quant(input logic [WIDE_W-1:0] x);
        logic [QUANT_W-1:0] sum;
        sum = (QUANT_W'(x) << 8) - QUANT_W'(x) + QUANT_HALF;
        return sum[2*FRAC_BITS+CHAN_W-1:2*FRAC_BITS];
    endfunction

    assign vw = widen(pqt.cc);

    always_comb
    begin
        r_next = '0;
        g_next = '0;
        b_next = '0;
        unique case (pqt.mode)
            MODE_RGB:
            begin
                r_next = widen(pqt.ca);
                g_next = widen(pqt.cb);
                b_next = widen(pqt.cc);
            end
            MODE_GRAY:
            begin
                r_next = widen(pqt.ca);
                g_next = widen(pqt.ca);
                b_next = widen(pqt.ca);
            end
            MODE_HSV:
            begin
                case (sextant_t'(pqt.hi))
                    SEXT_VTP:
                    begin
                        r_next = vw;     g_next = pqt.t;  b_next = pqt.p;
                    end
                    SEXT_QVP:
                    begin
                        r_next = pqt.q;  g_next = vw;     b_next = pqt.p;
                    end
                    SEXT_PVT:
                    begin
                        r_next = pqt.p;  g_next = vw;     b_next = pqt.t;
                    end
                    SEXT_PQV:
                    begin
                        r_next = pqt.p;  g_next = pqt.q;  b_next = vw;
                    end
                    SEXT_TPV:
                    begin
                        r_next = pqt.t;  g_next = pqt.p;  b_next = vw;
                    end
                    default:
                    begin
                        r_next = vw;     g_next = pqt.p;  b_next = pqt.q;
                    end
                endcase
            end
            MODE_NONE:
            begin
                r_next = '0;
                g_next = '0;
                b_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign red_next   = quant(r_reg);
    assign green_next = quant(g_reg);
    assign blue_next  = quant(b_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule
